@@ sv/mllq_pkg.sv @@
// ----------------------------------------------------------------------------
// mllq_pkg
// shared constants and types for the multi-list linked queue
// ----------------------------------------------------------------------------
package mllq_pkg;

    localparam int NUM_ENTRIES_DEF = 64;
    localparam int NUM_LISTS_DEF   = 16;

    localparam int CMD_W   = 2;
    localparam int LIST_W  = 4;
    localparam int ENTRY_W = 6;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HEAD,
        ST_POP_NX,
        ST_APP_WALK,
        ST_RM_HEAD,
        ST_RM_WALK,
        ST_RM_LINK,
        ST_RM_CLR,
        ST_DONE
    } mllq_state_t;

endpackage

@@ sv/multi_list_index_linked_queue.sv @@
// ----------------------------------------------------------------------------
// multi_list_index_linked_queue
// singly linked lists sharing one entry table; heads and next pointers are
// kept in two synchronous memories and walked one read per cycle
// ----------------------------------------------------------------------------
// sequence: the list head is read after accept; pop then unlinks the head,
//   append walks next pointers to the tail and links the entry there, remove
//   unlinks the head or walks to the entry and relinks its predecessor; walks
//   stop at NUM_ENTRIES steps; empty-list misses and bad requests skip to the
//   result; a held result stalls it; one word in flight, the next accepted once
//   the result is registered; reset clears both tables with s_ready low
module multi_list_index_linked_queue #(
    parameter int NUM_ENTRIES = mllq_pkg::NUM_ENTRIES_DEF,
    parameter int NUM_LISTS   = mllq_pkg::NUM_LISTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mllq_pkg::CMD_W-1:0]    s_cmd,
    input  logic [mllq_pkg::LIST_W-1:0]   s_list_sel,
    input  logic [mllq_pkg::ENTRY_W-1:0]  s_entry_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_status,
    output logic [mllq_pkg::ENTRY_W-1:0]  m_popped_entry
);

    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int SW = $clog2(NUM_ENTRIES + 1);
    localparam int CD = (NUM_ENTRIES > NUM_LISTS) ? NUM_ENTRIES : NUM_LISTS;
    localparam int CW = (CD > 1) ? $clog2(CD) : 1;

    typedef struct packed {
        logic          valid;
        logic [IW-1:0] idx;
    } ptr_t;

    // memories
    ptr_t hmem [NUM_LISTS];
    ptr_t nmem [NUM_ENTRIES];

    mllq_pkg::mllq_state_t state_reg, state_next;

    logic [mllq_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [LW-1:0]                lst_reg, lst_next;
    logic [IW-1:0]                ent_reg, ent_next;
    logic [IW-1:0]                cur_reg, cur_next;
    logic [SW-1:0]                step_reg, step_next;
    logic [CW-1:0]                clr_reg, clr_next;
    logic                         res_status_reg, res_status_next;
    logic [mllq_pkg::ENTRY_W-1:0] res_got_reg, res_got_next;
    logic                         m_valid_reg, m_valid_next;
    logic                         m_status_reg, m_status_next;
    logic [mllq_pkg::ENTRY_W-1:0] m_popped_reg, m_popped_next;
    ptr_t                         head_rd_reg, next_rd_reg;

    // memory ports
    logic          h_we, h_re, n_we, n_re;
    logic [LW-1:0] h_wa, h_ra;
    logic [IW-1:0] n_wa, n_ra;
    ptr_t          h_wd, n_wd;

    logic req_bad, walk_end, out_free, clr_last, s_acc;
    ptr_t ent_ptr;

    assign s_ready  = (state_reg == mllq_pkg::ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign req_bad  = (32'(s_list_sel) >= NUM_LISTS)
                   || (s_cmd != mllq_pkg::CMD_APPEND && s_cmd != mllq_pkg::CMD_POP
                       && s_cmd != mllq_pkg::CMD_REMOVE)
                   || (s_cmd != mllq_pkg::CMD_POP && 32'(s_entry_index) >= NUM_ENTRIES);
    assign walk_end = (step_reg >= SW'(NUM_ENTRIES));
    assign out_free = !m_valid_reg || m_ready;
    assign clr_last = (clr_reg == CW'(CD - 1));
    assign ent_ptr  = '{valid: 1'b1, idx: ent_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mllq_pkg::ST_CLEAR: begin
                if (clr_last) state_next = mllq_pkg::ST_IDLE;
            end
            mllq_pkg::ST_IDLE: begin
                if (s_acc) state_next = req_bad ? mllq_pkg::ST_DONE : mllq_pkg::ST_HEAD;
            end
            mllq_pkg::ST_HEAD: begin
                state_next = mllq_pkg::ST_DONE;
                if (head_rd_reg.valid) begin
                    case (cmd_reg)
                        mllq_pkg::CMD_POP:    state_next = mllq_pkg::ST_POP_NX;
                        mllq_pkg::CMD_APPEND: state_next = mllq_pkg::ST_APP_WALK;
                        mllq_pkg::CMD_REMOVE: begin
                            state_next = (head_rd_reg.idx == ent_reg) ?
                                         mllq_pkg::ST_RM_HEAD : mllq_pkg::ST_RM_WALK;
                        end
                        default: state_next = mllq_pkg::ST_DONE;
                    endcase
                end
            end
            mllq_pkg::ST_POP_NX:  state_next = mllq_pkg::ST_DONE;
            mllq_pkg::ST_APP_WALK: begin
                if (!next_rd_reg.valid || walk_end) state_next = mllq_pkg::ST_DONE;
            end
            mllq_pkg::ST_RM_HEAD: state_next = mllq_pkg::ST_DONE;
            mllq_pkg::ST_RM_WALK: begin
                if (!next_rd_reg.valid || walk_end) state_next = mllq_pkg::ST_DONE;
                else if (next_rd_reg.idx == ent_reg) state_next = mllq_pkg::ST_RM_LINK;
            end
            mllq_pkg::ST_RM_LINK: state_next = mllq_pkg::ST_RM_CLR;
            mllq_pkg::ST_RM_CLR:  state_next = mllq_pkg::ST_DONE;
            mllq_pkg::ST_DONE: begin
                if (out_free) state_next = mllq_pkg::ST_IDLE;
            end
            default: state_next = mllq_pkg::ST_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        cmd_next        = cmd_reg;
        lst_next        = lst_reg;
        ent_next        = ent_reg;
        cur_next        = cur_reg;
        step_next       = step_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_got_next    = res_got_reg;
        m_status_next   = m_status_reg;
        m_popped_next   = m_popped_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        h_we = 1'b0; h_wa = lst_reg; h_wd = '0;
        h_re = 1'b0; h_ra = LW'(s_list_sel);
        n_we = 1'b0; n_wa = cur_reg; n_wd = '0;
        n_re = 1'b0; n_ra = head_rd_reg.idx;
        case (state_reg)
            mllq_pkg::ST_CLEAR: begin
                clr_next = clr_reg + CW'(1);
                if (32'(clr_reg) < NUM_LISTS) begin
                    h_we = 1'b1;
                    h_wa = LW'(clr_reg);
                end
                if (32'(clr_reg) < NUM_ENTRIES) begin
                    n_we = 1'b1;
                    n_wa = IW'(clr_reg);
                end
            end
            mllq_pkg::ST_IDLE: begin
                if (s_acc) begin
                    cmd_next        = s_cmd;
                    lst_next        = LW'(s_list_sel);
                    ent_next        = IW'(s_entry_index);
                    res_status_next = mllq_pkg::STATUS_FAIL;
                    res_got_next    = '0;
                    h_re            = !req_bad;
                end
            end
            mllq_pkg::ST_HEAD: begin
                cur_next  = head_rd_reg.idx;
                step_next = '0;
                if (!head_rd_reg.valid) begin
                    // empty list: only append succeeds, it becomes the head
                    if (cmd_reg == mllq_pkg::CMD_APPEND) begin
                        h_we            = 1'b1;
                        h_wd            = ent_ptr;
                        res_status_next = mllq_pkg::STATUS_OK;
                    end
                end else begin
                    n_re = 1'b1;
                    n_ra = (cmd_reg == mllq_pkg::CMD_REMOVE && head_rd_reg.idx == ent_reg) ?
                           ent_reg : head_rd_reg.idx;
                end
            end
            mllq_pkg::ST_POP_NX: begin
                h_we            = 1'b1;
                h_wd            = next_rd_reg;
                n_we            = 1'b1;
                n_wa            = cur_reg;
                res_status_next = mllq_pkg::STATUS_OK;
                res_got_next    = mllq_pkg::ENTRY_W'(cur_reg);
            end
            mllq_pkg::ST_APP_WALK: begin
                if (!next_rd_reg.valid) begin
                    n_we            = 1'b1;
                    n_wa            = cur_reg;
                    n_wd            = ent_ptr;
                    res_status_next = mllq_pkg::STATUS_OK;
                end else if (!walk_end) begin
                    cur_next  = next_rd_reg.idx;
                    step_next = step_reg + SW'(1);
                    n_re      = 1'b1;
                    n_ra      = next_rd_reg.idx;
                end
            end
            mllq_pkg::ST_RM_HEAD: begin
                h_we            = 1'b1;
                h_wd            = next_rd_reg;
                n_we            = 1'b1;
                n_wa            = ent_reg;
                res_status_next = mllq_pkg::STATUS_OK;
            end
            mllq_pkg::ST_RM_WALK: begin
                if (next_rd_reg.valid && !walk_end) begin
                    n_re = 1'b1;
                    if (next_rd_reg.idx == ent_reg) begin
                        n_ra = ent_reg;
                    end else begin
                        // prev moves on to the entry just read
                        cur_next  = next_rd_reg.idx;
                        step_next = step_reg + SW'(1);
                        n_ra      = next_rd_reg.idx;
                    end
                end
            end
            mllq_pkg::ST_RM_LINK: begin
                n_we = 1'b1;
                n_wa = cur_reg;
                n_wd = next_rd_reg;
            end
            mllq_pkg::ST_RM_CLR: begin
                n_we            = 1'b1;
                n_wa            = ent_reg;
                res_status_next = mllq_pkg::STATUS_OK;
            end
            mllq_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_popped_next = res_got_reg;
                end
            end
            default: begin
                clr_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (h_we) hmem[h_wa] <= h_wd;
        if (h_re) head_rd_reg <= hmem[h_ra];
        if (n_we) nmem[n_wa] <= n_wd;
        if (n_re) next_rd_reg <= nmem[n_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mllq_pkg::ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        lst_reg        <= lst_next;
        ent_reg        <= ent_next;
        cur_reg        <= cur_next;
        step_reg       <= step_next;
        res_status_reg <= res_status_next;
        res_got_reg    <= res_got_next;
        m_status_reg   <= m_status_next;
        m_popped_reg   <= m_popped_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_popped_entry = m_popped_reg;

    // no result can appear while the tables are being cleared
    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mllq_pkg::ST_CLEAR) |-> !m_valid_reg)
        else $error("result valid during clearing pass");

    // walk never exceeds its bound
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mllq_pkg::ST_APP_WALK || state_reg == mllq_pkg::ST_RM_WALK)
        |-> (step_reg <= SW'(NUM_ENTRIES)))
        else $error("walk step count past bound");

    // next_link is never read and written in the same cycle
    a_next_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(n_we && n_re))
        else $error("next_link read and write collide");

    // a failed request reports entry zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == mllq_pkg::STATUS_FAIL) |-> (m_popped_reg == '0))
        else $error("failed request carries an entry");

endmodule

@@ tb/tb_multi_list_index_linked_queue.sv @@
// ----------------------------------------------------------------------------
// tb_multi_list_index_linked_queue
// self-checking bench for the shared-table linked list queue: a directed
// sequence through empty lists, head/inner/tail removal and looped chains,
// then rounds of random traffic checked against a tracked copy of the lists
// ----------------------------------------------------------------------------
module tb_multi_list_index_linked_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ENTRIES = mllq_pkg::NUM_ENTRIES_DEF;
    localparam int NUM_LISTS   = mllq_pkg::NUM_LISTS_DEF;
    localparam int CMD_W       = mllq_pkg::CMD_W;
    localparam int LIST_W      = mllq_pkg::LIST_W;
    localparam int ENTRY_W     = mllq_pkg::ENTRY_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ROUNDS      = 5;
    localparam int ROUND_WORDS = 100;

    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [ENTRY_W-1:0] idx;
    } link_t;

    typedef struct packed {
        link_t [NUM_LISTS-1:0]   head;
        link_t [NUM_ENTRIES-1:0] nxt;
    } chain_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [LIST_W-1:0]  list_sel;
        logic [ENTRY_W-1:0] entry;
    } request_t;

    typedef struct packed {
        logic               status;
        logic [ENTRY_W-1:0] popped;
    } outcome_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd         = '0;
    logic [LIST_W-1:0]   s_list_sel    = '0;
    logic [ENTRY_W-1:0]  s_entry_index = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic                m_status;
    logic [ENTRY_W-1:0]  m_popped_entry;

    chain_state_t plan_lists;   // lists as they will be once queued words are done
    chain_state_t dut_lists;    // lists as of the last accepted word
    request_t     pending_words[$];
    outcome_t     expected_results[$];

    int       n_errors    = 0;
    int       n_accepted  = 0;
    int       cycle_count = 0;
    int       gap_left    = 0;
    int       burst_left  = 1;
    int       hold_left   = 0;
    bit       hold_used   = 1'b0;
    bit       word_taken  = 1'b0;
    rx_mode_t rx_mode     = RX_OPEN;
    int       mode_left   = 0;

    multi_list_index_linked_queue #(
        .NUM_ENTRIES(NUM_ENTRIES),
        .NUM_LISTS  (NUM_LISTS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_list_sel    (s_list_sel),
        .s_entry_index (s_entry_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_popped_entry(m_popped_entry)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // applies one request to a set of lists and returns the result word
    function automatic outcome_t serve_request(inout chain_state_t s, input request_t r);
        outcome_t res;
        link_t    cur;
        link_t    prev;
        int       steps;
        bit       done;
        res.status = mllq_pkg::STATUS_FAIL;
        res.popped = '0;
        if (int'(r.list_sel) < NUM_LISTS) begin
            case (r.cmd)
                mllq_pkg::CMD_POP: begin
                    cur = s.head[r.list_sel];
                    if (cur.valid) begin
                        s.head[r.list_sel] = s.nxt[cur.idx];
                        s.nxt[cur.idx] = '0;
                        res.status = mllq_pkg::STATUS_OK;
                        res.popped = cur.idx;
                    end
                end
                mllq_pkg::CMD_APPEND: begin
                    cur = s.head[r.list_sel];
                    if (int'(r.entry) >= NUM_ENTRIES) begin
                        res.status = mllq_pkg::STATUS_FAIL;
                    end else if (!cur.valid) begin
                        s.head[r.list_sel] = {1'b1, r.entry};
                        res.status = mllq_pkg::STATUS_OK;
                    end else begin
                        steps = 0;
                        while (s.nxt[cur.idx].valid && steps < NUM_ENTRIES) begin
                            cur = s.nxt[cur.idx];
                            steps++;
                        end
                        // a looped chain never reaches a tail within the bound
                        if (!s.nxt[cur.idx].valid) begin
                            s.nxt[cur.idx] = {1'b1, r.entry};
                            res.status = mllq_pkg::STATUS_OK;
                        end
                    end
                end
                mllq_pkg::CMD_REMOVE: begin
                    prev = s.head[r.list_sel];
                    if (int'(r.entry) < NUM_ENTRIES && prev.valid) begin
                        if (prev.idx == r.entry) begin
                            s.head[r.list_sel] = s.nxt[r.entry];
                            s.nxt[r.entry] = '0;
                            res.status = mllq_pkg::STATUS_OK;
                        end else begin
                            cur   = s.nxt[prev.idx];
                            steps = 0;
                            done  = 1'b0;
                            while (cur.valid && steps < NUM_ENTRIES && !done) begin
                                if (cur.idx == r.entry) begin
                                    s.nxt[prev.idx] = s.nxt[r.entry];
                                    s.nxt[r.entry] = '0;
                                    res.status = mllq_pkg::STATUS_OK;
                                    done = 1'b1;
                                end else begin
                                    prev = cur;
                                    cur  = s.nxt[cur.idx];
                                    steps++;
                                end
                            end
                        end
                    end
                end
                default: res.status = mllq_pkg::STATUS_FAIL;
            endcase
        end
        return res;
    endfunction

    function automatic int chain_len(chain_state_t s, int l);
        link_t cur;
        int    n;
        cur = s.head[l];
        n   = 0;
        while (cur.valid && n < NUM_ENTRIES) begin
            n++;
            cur = s.nxt[cur.idx];
        end
        return n;
    endfunction

    function automatic logic [ENTRY_W-1:0] nth_member(chain_state_t s, int l, int k);
        link_t cur;
        cur = s.head[l];
        for (int i = 0; i < k; i++) cur = s.nxt[cur.idx];
        return cur.idx;
    endfunction

    // an entry nothing points at, or -1 when the table is used up
    function automatic int find_free(chain_state_t s);
        bit [NUM_ENTRIES-1:0] used;
        int                   base;
        int                   e;
        used = '0;
        for (int i = 0; i < NUM_LISTS; i++)
            if (s.head[i].valid) used[s.head[i].idx] = 1'b1;
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (s.nxt[i].valid) used[s.nxt[i].idx] = 1'b1;
        base = $urandom_range(0, NUM_ENTRIES - 1);
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            e = (base + i) % NUM_ENTRIES;
            if (!used[e]) return e;
        end
        return -1;
    endfunction

    task automatic queue_item(input logic [CMD_W-1:0] c, input logic [LIST_W-1:0] l,
                              input logic [ENTRY_W-1:0] e);
        request_t r;
        r = {c, l, e};
        void'(serve_request(plan_lists, r));
        pending_words.push_back(r);
    endtask

    // mostly well-formed traffic on a few busy lists, some broken requests
    task automatic add_random_item();
        int                 roll;
        int                 l;
        int                 f;
        int                 n;
        logic [ENTRY_W-1:0] e;
        roll = $urandom_range(0, 99);
        l    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_LISTS - 1)
                                           : $urandom_range(0, 3);
        e    = ENTRY_W'($urandom);
        if (roll < 45) begin
            f = find_free(plan_lists);
            if (f < 0) begin
                queue_item(mllq_pkg::CMD_POP, LIST_W'(l), e);
            end else begin
                // now and then append a random entry, which may already be linked
                if ($urandom_range(0, 9) != 0) e = ENTRY_W'(f);
                queue_item(mllq_pkg::CMD_APPEND, LIST_W'(l), e);
            end
        end else if (roll < 70) begin
            queue_item(mllq_pkg::CMD_POP, LIST_W'(l), e);
        end else if (roll < 95) begin
            n = chain_len(plan_lists, l);
            if (n > 0 && $urandom_range(0, 3) != 0)
                e = nth_member(plan_lists, l, $urandom_range(0, n - 1));
            queue_item(mllq_pkg::CMD_REMOVE, LIST_W'(l), e);
        end else begin
            queue_item(CMD_RESERVED, LIST_W'(l), e);
        end
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic flag_error(input string what, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch at %0t ns: %s expected %0h got %0h", $time, what, exp_v, act_v);
    endtask

    // acceptance of input words and checking of result words
    always @(posedge aclk) begin : watch_ports
        outcome_t want;
        word_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                word_taken = 1'b1;
                n_accepted++;
                expected_results.push_back(
                    serve_request(dut_lists, {s_cmd, s_list_sel, s_entry_index}));
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    flag_error("unexpected word, status", 8'hff, {7'd0, m_status});
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status)
                        flag_error("status", {7'd0, want.status}, {7'd0, m_status});
                    if (m_popped_entry !== want.popped)
                        flag_error("popped_entry", {2'd0, want.popped}, {2'd0, m_popped_entry});
                end
            end
        end
    end

    // long receiver hold-off once traffic is under way
    always @(posedge aclk) begin : hold_timer
        if (hold_left > 0) begin
            hold_left--;
        end else if (!hold_used && n_accepted >= 60) begin
            hold_left = 600;
            hold_used = 1'b1;
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** multi_list_index_linked_queue: FAILED **");
            $finish;
        end
    end

    // sender: bursts of words with random gaps between them
    always @(negedge aclk) begin : drive_inputs
        request_t nxt_word;
        logic     nxt_valid;
        nxt_valid = s_valid;
        if (aresetn && (!s_valid || word_taken)) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_words.size() > 0) begin
                nxt_word      = pending_words.pop_front();
                s_cmd         <= nxt_word.cmd;
                s_list_sel    <= nxt_word.list_sel;
                s_entry_index <= nxt_word.entry;
                nxt_valid     = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    if ($urandom_range(0, 2) == 0)
                        gap_left = 0;
                    else if ($urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(20, 80);
                    else
                        gap_left = $urandom_range(1, 8);
                end
            end
        end
        s_valid <= nxt_valid;
    end

    // receiver: stall pattern that changes mode every so often
    always @(negedge aclk) begin : drive_ready
        logic rdy;
        if (mode_left == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (rx_mode)
            RX_OPEN:   rdy = 1'b1;
            RX_COIN:   rdy = 1'($urandom_range(0, 1));
            RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
            default:   rdy = ~m_ready;
        endcase
        m_ready <= rdy && (hold_left == 0);
    end

    initial begin
        plan_lists = '0;
        dut_lists  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // empty lists, then head / inner / tail removal and a miss
        queue_item(mllq_pkg::CMD_POP,    4'd0,  6'd0);
        queue_item(mllq_pkg::CMD_REMOVE, 4'd0,  6'd5);
        queue_item(mllq_pkg::CMD_APPEND, 4'd0,  6'd0);
        queue_item(mllq_pkg::CMD_APPEND, 4'd0,  6'd63);
        queue_item(mllq_pkg::CMD_APPEND, 4'd0,  6'd21);
        queue_item(mllq_pkg::CMD_APPEND, 4'd0,  6'd42);
        queue_item(mllq_pkg::CMD_APPEND, 4'd15, 6'd1);
        queue_item(mllq_pkg::CMD_REMOVE, 4'd0,  6'd21);
        queue_item(mllq_pkg::CMD_REMOVE, 4'd0,  6'd0);
        queue_item(mllq_pkg::CMD_REMOVE, 4'd0,  6'd42);
        queue_item(mllq_pkg::CMD_REMOVE, 4'd0,  6'd7);
        queue_item(CMD_RESERVED,         4'd15, 6'd63);
        queue_item(mllq_pkg::CMD_POP,    4'd15, 6'd63);
        queue_item(mllq_pkg::CMD_POP,    4'd0,  6'd0);
        // relink an entry already in the list: the chain loops back on itself
        queue_item(mllq_pkg::CMD_APPEND, 4'd3,  6'd10);
        queue_item(mllq_pkg::CMD_APPEND, 4'd3,  6'd11);
        queue_item(mllq_pkg::CMD_APPEND, 4'd3,  6'd10);
        queue_item(mllq_pkg::CMD_APPEND, 4'd3,  6'd12);
        queue_item(mllq_pkg::CMD_REMOVE, 4'd3,  6'd12);
        queue_item(mllq_pkg::CMD_REMOVE, 4'd3,  6'd11);
        queue_item(mllq_pkg::CMD_POP,    4'd3,  6'd0);
        queue_item(mllq_pkg::CMD_POP,    4'd3,  6'd0);
        queue_item(mllq_pkg::CMD_POP,    4'd3,  6'd0);
        wait_idle();

        for (int rnd = 0; rnd < ROUNDS; rnd++) begin
            for (int i = 0; i < ROUND_WORDS; i++) add_random_item();
            // empty every list once midway, looped chains included
            if (rnd == 2) begin
                for (int l = 0; l < NUM_LISTS; l++)
                    while (plan_lists.head[l].valid)
                        queue_item(mllq_pkg::CMD_POP, LIST_W'(l), ENTRY_W'($urandom));
            end
            wait_idle();
        end

        repeat (150) @(posedge aclk);
        if (expected_results.size() != 0) n_errors++;
        if (n_errors == 0) begin
            $display("** multi_list_index_linked_queue: PASSED **");
        end else begin
            $display("** multi_list_index_linked_queue: FAILED **");
        end
        $finish;
    end

endmodule
